// ----- src/gdu_pkg.sv -----
// Shared types, constants and calendar tables for the Gregorian date unit.
package gdu_pkg;

  // First year of the supported calendar range.
  localparam logic [13:0] FIRST_YEAR = 14'd1753;

  // Leap years in 1..1752, removed so the count starts at the first year.
  localparam logic [14:0] LEAPS_BEFORE_FIRST = 15'd425;

  // Reciprocal of 25 for 12-bit operands: floor(x / 25) = (x * RECIP25_S) >> 17.
  localparam logic [12:0] RECIP25_S = 13'd5243;
  localparam int unsigned RECIP25_S_SHIFT = 17;

  // Reciprocal of 25 for 14-bit operands: floor(x / 25) = (x * RECIP25_L) >> 20.
  localparam logic [15:0] RECIP25_L = 16'd41944;
  localparam int unsigned RECIP25_L_SHIFT = 20;

  // Reciprocal of 7 for 15-bit operands: floor(x / 7) = (x * RECIP7) >> 20.
  localparam logic [17:0] RECIP7 = 18'd149797;
  localparam int unsigned RECIP7_SHIFT = 20;

  // Month codes used by the rollover logic.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // One input date.
  typedef struct packed {
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] year_in;
  } gdu_in_t;

  // One result.
  typedef struct packed {
    logic        date_valid;
    logic        leap_flag;
    logic [8:0]  ordinal_day;
    logic [2:0]  weekday;
    logic [3:0]  next_month;
    logic [4:0]  next_day;
    logic [13:0] next_year;
  } gdu_out_t;

  // Length of a month; February grows to 29 days in a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/gregorian_date_unit_core.sv -----
// Top level of the Gregorian date unit: a five-stage date pipeline.
//
// The unit takes one Gregorian date per clock cycle while in_stall is low and
// returns its validity, leap-year flag, day of the year, day of the week
// (0 is Sunday) and the following date. Each stage holds its own valid bit and
// moves as soon as the stage after it is empty or moving, so bubbles close up
// and a stalled output holds only the items behind it. The pipeline depth is
// set by the two reciprocal multiplies (divide by 100 and 25 in the
// first stage, remainder by seven in the fourth) and the registers around them.
// Dates before 1753, months outside 1 to 12 and days outside the month give
// date_valid low with every other field zero. The following year wraps at
// 16384.
module gregorian_date_unit_core import gdu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gdu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gdu_out_t out_data
);

  // Stage valid bits and per-stage move enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: register the date with the two divide-by-25 products.
  logic [3:0]  m1_r;
  logic [4:0]  d1_r;
  logic [13:0] y1_r;
  logic [24:0] p100_r;
  logic [24:0] p100_nxt;
  logic [29:0] p25_r;
  logic [29:0] p25_nxt;
  logic [13:0] ym1_in;

  assign ym1_in   = in_data.year_in - 14'd1;
  assign p100_nxt = 25'(ym1_in[13:2]) * 25'(RECIP25_S);
  assign p25_nxt  = 30'(in_data.year_in) * 30'(RECIP25_L);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      m1_r   <= in_data.month_in;
      d1_r   <= in_data.day_in;
      y1_r   <= in_data.year_in;
      p100_r <= p100_nxt;
      p25_r  <= p25_nxt;
    end
  end

  // Stage 2: leap test, month length, validity and leap-year count.
  logic [11:0] q4_s2;
  logic [7:0]  q100_s2;
  logic [5:0]  q400_s2;
  logic [9:0]  q25_s2;
  logic [13:0] r25_s2;
  logic        leap_s2;
  logic [4:0]  mlen_s2;
  logic        ok_s2;
  logic [14:0] leaps_s2;
  logic [13:0] ym1_s2;

  assign ym1_s2  = y1_r - 14'd1;
  assign q4_s2   = ym1_s2[13:2];
  assign q100_s2 = p100_r[RECIP25_S_SHIFT +: 8];
  assign q400_s2 = q100_s2[7:2];
  assign q25_s2  = p25_r[RECIP25_L_SHIFT +: 10];
  assign r25_s2  = y1_r - 14'({q25_s2, 4'b0000} + {q25_s2, 3'b000} + 14'(q25_s2));
  assign leap_s2 = (y1_r[1:0] == 2'b00) && ((r25_s2 != 14'd0) || (y1_r[3:0] == 4'd0));
  assign mlen_s2 = month_len(m1_r, leap_s2);
  assign ok_s2   = (m1_r >= MONTH_JAN) && (m1_r <= MONTH_DEC) && (y1_r >= FIRST_YEAR) &&
                   (d1_r != 5'd0) && (d1_r <= mlen_s2);
  assign leaps_s2 = 15'(q4_s2) - 15'(q100_s2) + 15'(q400_s2) - LEAPS_BEFORE_FIRST;

  logic [3:0]  m2_r;
  logic [4:0]  d2_r;
  logic [13:0] y2_r;
  logic        leap2_r;
  logic [4:0]  mlen2_r;
  logic        ok2_r;
  logic [14:0] leaps2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      m2_r     <= m1_r;
      d2_r     <= d1_r;
      y2_r     <= y1_r;
      leap2_r  <= leap_s2;
      mlen2_r  <= mlen_s2;
      ok2_r    <= ok_s2;
      leaps2_r <= leaps_s2;
    end
  end

  // Stage 3: ordinal day, day count for the weekday and the following date.
  logic [8:0]  ord_s3;
  logic [14:0] sum_s3;
  logic [3:0]  nm_s3;
  logic [4:0]  nd_s3;
  logic [13:0] ny_s3;
  logic [13:0] span_s3;

  assign ord_s3  = days_before(m2_r) + 9'(d2_r) + 9'(leap2_r && (m2_r > MONTH_FEB));
  assign span_s3 = y2_r - FIRST_YEAR;
  // 365 is one more than a multiple of seven, so each year adds one weekday.
  assign sum_s3  = 15'(span_s3) + leaps2_r + 15'(ord_s3);

  always_comb begin
    nm_s3 = m2_r;
    nd_s3 = d2_r + 5'd1;
    ny_s3 = y2_r;
    if (d2_r >= mlen2_r) begin
      nd_s3 = 5'd1;
      if (m2_r < MONTH_DEC) begin
        nm_s3 = m2_r + 4'd1;
      end else begin
        nm_s3 = MONTH_JAN;
        ny_s3 = y2_r + 14'd1;
      end
    end
  end

  gdu_out_t    res3_r;
  gdu_out_t    res3_nxt;
  logic [14:0] sum3_r;

  always_comb begin
    res3_nxt = '0;
    if (ok2_r) begin
      res3_nxt.date_valid  = 1'b1;
      res3_nxt.leap_flag   = leap2_r;
      res3_nxt.ordinal_day = ord_s3;
      res3_nxt.next_month  = nm_s3;
      res3_nxt.next_day    = nd_s3;
      res3_nxt.next_year   = ny_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      res3_r <= res3_nxt;
      sum3_r <= ok2_r ? sum_s3 : 15'd0;
    end
  end

  // Stages 4 and 5: weekday remainder, with the other fields carried along.
  logic [2:0] weekday;
  gdu_out_t   res4_r;
  gdu_out_t   res5_r;

  gdu_mod7 u_mod7 (
    .clk       (clk),
    .load_prod (rdy4),
    .load_rem  (rdy5),
    .value     (sum3_r),
    .rem       (weekday)
  );

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res4_r <= res3_r;
    end
    if (rdy5) begin
      res5_r <= res4_r;
    end
  end

  // Output transfer.
  always_comb begin
    out_data         = res5_r;
    out_data.weekday = weekday;
  end

  assign out_valid = v5_r;

endmodule

// ----- src/gdu_mod7.sv -----
// Two-stage remainder by seven using a reciprocal multiply and a correction subtract.
module gdu_mod7 import gdu_pkg::*; (
  input  logic        clk,
  input  logic        load_prod,
  input  logic        load_rem,
  input  logic [14:0] value,
  output logic [2:0]  rem
);

  logic [32:0] prod_r;
  logic [32:0] prod_nxt;
  logic [14:0] value_r;
  logic [2:0]  rem_r;
  logic [2:0]  rem_nxt;
  logic [12:0] quot;
  logic [14:0] quot_x7;
  logic [14:0] diff;

  // First stage: multiply by the scaled reciprocal of seven.
  assign prod_nxt = 33'(value) * 33'(RECIP7);

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_r  <= prod_nxt;
      value_r <= value;
    end
  end

  // Second stage: take the quotient and subtract seven times it.
  assign quot    = prod_r[RECIP7_SHIFT +: 13];
  assign quot_x7 = 15'({quot, 3'b000} - {2'b00, quot});
  assign diff    = value_r - quot_x7;
  assign rem_nxt = diff[2:0];

  always_ff @(posedge clk) begin
    if (load_rem) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule
